/* hdl/rmq_pkg.sv */
// shared types, widths and codes for the rotation matrix to quaternion converter
package rmq_pkg;

    localparam int DATA_W = 16;
    localparam int FRAC   = DATA_W - 2;
    localparam int SUM_W  = DATA_W + 2;
    localparam int ARG_W  = DATA_W + 1;
    localparam int MAG_W  = DATA_W + 1;
    localparam int RAD_W  = 2 * DATA_W;
    localparam int ROOT_W = DATA_W;
    localparam int REM_W  = DATA_W + 2;
    localparam int NUM_W  = 2 * DATA_W - 1;
    localparam int DEN_W  = DATA_W + 1;
    localparam int QUO_W  = DATA_W - 1;
    localparam int CMP_W  = 2 * DATA_W;

    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< FRAC;

    typedef logic signed [DATA_W-1:0] elem_t;

    typedef struct packed {
        elem_t e00;
        elem_t e01;
        elem_t e02;
        elem_t e10;
        elem_t e11;
        elem_t e12;
        elem_t e20;
        elem_t e21;
        elem_t e22;
    } rmq_req_t;

    typedef struct packed {
        elem_t qw;
        elem_t qx;
        elem_t qy;
        elem_t qz;
        logic  invalid;
    } rmq_res_t;

    // which component comes straight from the square root
    typedef enum logic [1:0] {
        LEAD_W,
        LEAD_X,
        LEAD_Y,
        LEAD_Z
    } lead_t;

    // classified request handed from the front to the back
    typedef struct packed {
        logic [ARG_W-1:0]  arg;
        logic              invalid;
        lead_t             lead;
        logic [2:0]        neg;
        logic [MAG_W-1:0]  mag_a;
        logic [MAG_W-1:0]  mag_b;
        logic [MAG_W-1:0]  mag_c;
    } rmq_job_t;

endpackage

/* hdl/rmq_front.sv */
// front end: trace test, leading axis choice, root argument and the three numerators
module rmq_front (
    input  rmq_pkg::rmq_req_t req,
    output rmq_pkg::rmq_job_t job
);
    import rmq_pkg::*;

    logic signed [SUM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [SUM_W-1:0] tr, arg, da, db, dc;
    logic                    tr_pos;
    lead_t                   lead;

    // sign extend the elements
    always_comb
    begin
        m00 = SUM_W'(req.e00);
        m01 = SUM_W'(req.e01);
        m02 = SUM_W'(req.e02);
        m10 = SUM_W'(req.e10);
        m11 = SUM_W'(req.e11);
        m12 = SUM_W'(req.e12);
        m20 = SUM_W'(req.e20);
        m21 = SUM_W'(req.e21);
        m22 = SUM_W'(req.e22);
    end

    // pick the branch and the leading component
    always_comb
    begin
        tr     = m00 + m11 + m22;
        tr_pos = tr > 0;
        if (tr_pos)
            lead = LEAD_W;
        else if (m22 > ((m11 > m00) ? m11 : m00))
            lead = LEAD_Z;
        else if (m11 > m00)
            lead = LEAD_Y;
        else
            lead = LEAD_X;
    end

    // root argument and numerators per branch
    always_comb
    begin
        unique case (lead)
            LEAD_W:
            begin
                arg = tr + ONE;
                da  = m12 - m21;
                db  = m20 - m02;
                dc  = m01 - m10;
            end
            LEAD_X:
            begin
                arg = m00 - (m11 + m22) + ONE;
                da  = m12 - m21;
                db  = m01 + m10;
                dc  = m02 + m20;
            end
            LEAD_Y:
            begin
                arg = m11 - (m22 + m00) + ONE;
                da  = m20 - m02;
                db  = m12 + m21;
                dc  = m10 + m01;
            end
            default:
            begin
                arg = m22 - (m00 + m11) + ONE;
                da  = m01 - m10;
                db  = m20 + m02;
                dc  = m21 + m12;
            end
        endcase
    end

    // pack into sign and magnitude
    always_comb
    begin
        job.invalid = !tr_pos && (arg <= 0);
        job.arg     = job.invalid ? ARG_W'(1) : arg[ARG_W-1:0];
        job.lead    = lead;
        job.neg     = {da[SUM_W-1], db[SUM_W-1], dc[SUM_W-1]};
        job.mag_a   = da[SUM_W-1] ? MAG_W'(-da) : da[MAG_W-1:0];
        job.mag_b   = db[SUM_W-1] ? MAG_W'(-db) : db[MAG_W-1:0];
        job.mag_c   = dc[SUM_W-1] ? MAG_W'(-dc) : dc[MAG_W-1:0];
    end

endmodule

/* hdl/rmq_queue.sv */
// two-entry queue between the front end and the arithmetic pipeline
module rmq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rmq_pkg::rmq_job_t wr_job,
    input  logic              pop,
    output logic              full,
    output logic              rd_valid,
    output rmq_pkg::rmq_job_t rd_job
);
    import rmq_pkg::*;

    rmq_job_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full     = count_reg == 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

/* hdl/rmq_back.sv */
// back end: pipelined square root, three pipelined dividers and output formatting
module rmq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rmq_pkg::rmq_job_t in_job,
    output logic              done,
    output rmq_pkg::rmq_res_t res
);
    import rmq_pkg::*;

    // square root stages
    logic                  sq_valid_reg [ROOT_W+1];
    logic [RAD_W-1:0]      sq_rad_reg   [ROOT_W+1];
    logic [REM_W-1:0]      sq_rem_reg   [ROOT_W+1];
    logic [ROOT_W-1:0]     sq_root_reg  [ROOT_W+1];
    rmq_job_t              sq_job_reg   [ROOT_W+1];
    logic [RAD_W-1:0]      sq_rad_next  [ROOT_W];
    logic [REM_W-1:0]      sq_rem_next  [ROOT_W];
    logic [ROOT_W-1:0]     sq_root_next [ROOT_W];

    // divider stages, three lanes each
    logic                  dv_valid_reg [QUO_W+1];
    logic [NUM_W-1:0]      dv_rem_reg   [QUO_W+1][3];
    logic [QUO_W-1:0]      dv_quo_reg   [QUO_W+1][3];
    logic [2:0]            dv_sat_reg   [QUO_W+1];
    logic [DEN_W-1:0]      dv_den_reg   [QUO_W+1];
    logic [ROOT_W-1:0]     dv_root_reg  [QUO_W+1];
    logic [2:0]            dv_neg_reg   [QUO_W+1];
    lead_t                 dv_lead_reg  [QUO_W+1];
    logic                  dv_inv_reg   [QUO_W+1];
    logic [NUM_W-1:0]      dv_rem_next  [QUO_W][3];
    logic [QUO_W-1:0]      dv_quo_next  [QUO_W][3];

    logic [NUM_W-1:0]      num0 [3];
    logic [2:0]            sat0;
    logic [DEN_W-1:0]      den0;
    logic [MAG_W-1:0]      mag0 [3];

    logic                  done_reg;
    rmq_res_t              res_reg, res_next;
    elem_t                 q_lead, q_a, q_b, q_c;
    logic [ROOT_W:0]       lead_sum;

    // one root digit per stage
    always_comb
    begin
        for (int s = 0; s < ROOT_W; s++)
        begin
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            rem_sh = {sq_rem_reg[s][REM_W-3:0], sq_rad_reg[s][RAD_W-1 -: 2]};
            trial  = {sq_root_reg[s], 2'b01};
            sq_rad_next[s] = sq_rad_reg[s] << 2;
            if (rem_sh >= trial)
            begin
                sq_rem_next[s]  = rem_sh - trial;
                sq_root_next[s] = {sq_root_reg[s][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[s]  = rem_sh;
                sq_root_next[s] = {sq_root_reg[s][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // divider setup from the finished root
    always_comb
    begin
        den0    = {sq_root_reg[ROOT_W], 1'b0};
        mag0[0] = sq_job_reg[ROOT_W].mag_a;
        mag0[1] = sq_job_reg[ROOT_W].mag_b;
        mag0[2] = sq_job_reg[ROOT_W].mag_c;
        for (int l = 0; l < 3; l++)
        begin
            num0[l] = NUM_W'({mag0[l], FRAC'(0)}) + NUM_W'(sq_root_reg[ROOT_W]);
            sat0[l] = CMP_W'(num0[l]) >= (CMP_W'(den0) << QUO_W);
        end
    end

    // one quotient bit per stage
    always_comb
    begin
        for (int d = 0; d < QUO_W; d++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [CMP_W-1:0] shifted;
                shifted = CMP_W'(dv_den_reg[d]) << (QUO_W - 1 - d);
                if (CMP_W'(dv_rem_reg[d][l]) >= shifted)
                begin
                    dv_rem_next[d][l] = dv_rem_reg[d][l] - shifted[NUM_W-1:0];
                    dv_quo_next[d][l] = {dv_quo_reg[d][l][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[d][l] = dv_rem_reg[d][l];
                    dv_quo_next[d][l] = {dv_quo_reg[d][l][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // sign, saturation and placement of the components
    function automatic elem_t fmt(input logic neg, input logic sat, input logic [QUO_W-1:0] q);
        elem_t v;
        if (sat)
            v = neg ? {1'b1, QUO_W'(0)} : {1'b0, {QUO_W{1'b1}}};
        else
            v = neg ? -elem_t'({1'b0, q}) : elem_t'({1'b0, q});
        return v;
    endfunction

    always_comb
    begin
        lead_sum = {1'b0, dv_root_reg[QUO_W]} + (ROOT_W+1)'(1);
        q_lead   = lead_sum[ROOT_W] ? {1'b0, {QUO_W{1'b1}}} : elem_t'(lead_sum[ROOT_W:1]);
        if (lead_sum[ROOT_W:1] >= (ROOT_W)'(1) << QUO_W)
            q_lead = {1'b0, {QUO_W{1'b1}}};
        q_a = fmt(dv_neg_reg[QUO_W][2], dv_sat_reg[QUO_W][0], dv_quo_reg[QUO_W][0]);
        q_b = fmt(dv_neg_reg[QUO_W][1], dv_sat_reg[QUO_W][1], dv_quo_reg[QUO_W][1]);
        q_c = fmt(dv_neg_reg[QUO_W][0], dv_sat_reg[QUO_W][2], dv_quo_reg[QUO_W][2]);
        unique case (dv_lead_reg[QUO_W])
            LEAD_W:
            begin
                res_next.qw = q_lead;
                res_next.qx = q_a;
                res_next.qy = q_b;
                res_next.qz = q_c;
            end
            LEAD_X:
            begin
                res_next.qw = q_a;
                res_next.qx = q_lead;
                res_next.qy = q_b;
                res_next.qz = q_c;
            end
            LEAD_Y:
            begin
                res_next.qw = q_a;
                res_next.qx = q_c;
                res_next.qy = q_lead;
                res_next.qz = q_b;
            end
            default:
            begin
                res_next.qw = q_a;
                res_next.qx = q_b;
                res_next.qy = q_c;
                res_next.qz = q_lead;
            end
        endcase
        res_next.invalid = dv_inv_reg[QUO_W];
        if (dv_inv_reg[QUO_W])
        begin
            res_next.qw = '0;
            res_next.qx = '0;
            res_next.qy = '0;
            res_next.qz = '0;
        end
    end

    // valid flags through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= ROOT_W; s++)
                sq_valid_reg[s] <= 1'b0;
            for (int d = 0; d <= QUO_W; d++)
                dv_valid_reg[d] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg[0] <= in_valid;
            for (int s = 0; s < ROOT_W; s++)
                sq_valid_reg[s+1] <= sq_valid_reg[s];
            dv_valid_reg[0] <= sq_valid_reg[ROOT_W];
            for (int d = 0; d < QUO_W; d++)
                dv_valid_reg[d+1] <= dv_valid_reg[d];
            done_reg <= dv_valid_reg[QUO_W];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        sq_rad_reg[0]  <= RAD_W'({in_job.arg, FRAC'(0)});
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_job_reg[0]  <= in_job;
        for (int s = 0; s < ROOT_W; s++)
        begin
            sq_rad_reg[s+1]  <= sq_rad_next[s];
            sq_rem_reg[s+1]  <= sq_rem_next[s];
            sq_root_reg[s+1] <= sq_root_next[s];
            sq_job_reg[s+1]  <= sq_job_reg[s];
        end
        for (int l = 0; l < 3; l++)
        begin
            dv_rem_reg[0][l] <= num0[l];
            dv_quo_reg[0][l] <= '0;
        end
        dv_sat_reg[0]  <= sat0;
        dv_den_reg[0]  <= den0;
        dv_root_reg[0] <= sq_root_reg[ROOT_W];
        dv_neg_reg[0]  <= sq_job_reg[ROOT_W].neg;
        dv_lead_reg[0] <= sq_job_reg[ROOT_W].lead;
        dv_inv_reg[0]  <= sq_job_reg[ROOT_W].invalid;
        for (int d = 0; d < QUO_W; d++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                dv_rem_reg[d+1][l] <= dv_rem_next[d][l];
                dv_quo_reg[d+1][l] <= dv_quo_next[d][l];
            end
            dv_sat_reg[d+1]  <= dv_sat_reg[d];
            dv_den_reg[d+1]  <= dv_den_reg[d];
            dv_root_reg[d+1] <= dv_root_reg[d];
            dv_neg_reg[d+1]  <= dv_neg_reg[d];
            dv_lead_reg[d+1] <= dv_lead_reg[d];
            dv_inv_reg[d+1]  <= dv_inv_reg[d];
        end
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* hdl/rotation_matrix_to_quaternion_top.sv */
// Rotation matrix to quaternion converter (Shepperd's method), Q2.14 in and out.
// A request is taken whenever start is high and busy is low; one matrix can
// be given every cycle. Each request gives one result on result, marked by a
// one-cycle done strobe. The path runs through the queue write, the root input
// register and 16 root stages (one root bit per stage), divider setup, three
// parallel dividers of 15 stages (one quotient bit per stage) and the output
// register. Results come out in request order and cannot be held off; busy
// only rises if the queue in front of the pipeline fills, which the
// free-running pipeline never lets happen.
module rotation_matrix_to_quaternion_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rmq_pkg::rmq_req_t request,
    output logic             done,
    output rmq_pkg::rmq_res_t result
);
    import rmq_pkg::*;

    rmq_job_t front_job;
    rmq_job_t queue_job;
    logic     queue_full;
    logic     queue_valid;

    // classify the request
    rmq_front u_front (
        .req (request),
        .job (front_job)
    );

    // decouple front and back
    rmq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start && !queue_full),
        .wr_job   (front_job),
        .pop      (1'b1),
        .full     (queue_full),
        .rd_valid (queue_valid),
        .rd_job   (queue_job)
    );

    // arithmetic pipeline
    rmq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (queue_valid),
        .in_job   (queue_job),
        .done     (done),
        .res      (result)
    );

    assign busy = queue_full;

endmodule

/* hdl/rmq_checker.sv */
// port-level checks for the converter and their binding to the top level
module rmq_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             busy,
    input  logic             done,
    input  rmq_pkg::rmq_res_t result
);
    import rmq_pkg::*;

    // the pipeline drains every cycle so the queue never fills
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // an invalid result carries all-zero components
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.invalid |->
            result.qw == '0 && result.qx == '0 && result.qy == '0 && result.qz == '0)
        else $error("invalid result with nonzero components");

    // a valid result has at least one nonzero component
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.invalid |->
            result.qw != '0 || result.qx != '0 || result.qy != '0 || result.qz != '0)
        else $error("valid result is all zero");

    // no result directly out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(rst_n))
        else $error("result right after reset");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

/* dv/tb.sv */
// self-checking testbench for the rotation matrix to quaternion converter
`timescale 1ns / 100ps

module tb;
    import rmq_pkg::*;

    localparam int LATENCY   = 35;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 1700;
    localparam logic signed [15:0] P1 = 16'sh4000;
    localparam logic signed [15:0] M1 = -16'sh4000;
    localparam logic signed [15:0] MAXV = 16'sh7fff;
    localparam logic signed [15:0] MINV = -16'sh8000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    rmq_req_t  request;
    logic      done;
    rmq_res_t  result;

    rmq_res_t  quat_queue[$];
    int        n_err;
    int        n_req;
    int        n_res;
    int        n_invalid;
    longint    cycles;

    rotation_matrix_to_quaternion_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor square root
    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // clamp sign and magnitude to the element format
    function automatic elem_t clamp(bit neg, longint unsigned mag);
        if (neg)
            return (mag >= 64'd32768) ? MINV : elem_t'(-longint'(mag));
        return (mag >= 64'd32768) ? MAXV : elem_t'(mag);
    endfunction

    // difference over twice the root, rounded half away from zero
    function automatic elem_t div_by_root(longint d, longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((mag << FRAC) + r) / (2 * r);
        return clamp(d < 0 && q != 0, q);
    endfunction

    // expected quaternion for one matrix
    function automatic rmq_res_t quat_of(rmq_req_t rq);
        longint m[3][3];
        elem_t q[4];
        longint tr;
        longint arg;
        longint unsigned r;
        int i;
        int j;
        int k;
        rmq_res_t o;
        m[0][0] = rq.e00; m[0][1] = rq.e01; m[0][2] = rq.e02;
        m[1][0] = rq.e10; m[1][1] = rq.e11; m[1][2] = rq.e12;
        m[2][0] = rq.e20; m[2][1] = rq.e21; m[2][2] = rq.e22;
        o = '0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            r = isqrt(longint'(tr + 16384) << FRAC);
            q[0] = clamp(0, (r + 1) >> 1);
            q[1] = div_by_root(m[1][2] - m[2][1], r);
            q[2] = div_by_root(m[2][0] - m[0][2], r);
            q[3] = div_by_root(m[0][1] - m[1][0], r);
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            arg = m[i][i] - (m[j][j] + m[k][k]) + 16384;
            if (arg <= 0)
            begin
                o.invalid = 1'b1;
                return o;
            end
            r = isqrt(longint'(arg) << FRAC);
            q[i + 1] = clamp(0, (r + 1) >> 1);
            q[0] = div_by_root(m[j][k] - m[k][j], r);
            q[j + 1] = div_by_root(m[i][j] + m[j][i], r);
            q[k + 1] = div_by_root(m[i][k] + m[k][i], r);
        end
        o.qw = q[0];
        o.qx = q[1];
        o.qy = q[2];
        o.qz = q[3];
        return o;
    endfunction

    task automatic report(string what, rmq_res_t got, rmq_res_t want);
        n_err++;
        $display("mismatch %s at result %0d: got %h want %h", what, n_res, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        rmq_res_t w;
        if (rst_n && done)
        begin
            if (quat_queue.size() == 0)
                report("unexpected", result, '0);
            else
            begin
                w = quat_queue.pop_front();
                if (result.qw !== w.qw)
                    report("qw", result, w);
                if (result.qx !== w.qx)
                    report("qx", result, w);
                if (result.qy !== w.qy)
                    report("qy", result, w);
                if (result.qz !== w.qz)
                    report("qz", result, w);
                if (result.invalid !== w.invalid)
                    report("invalid", result, w);
                if (w.invalid)
                    n_invalid++;
            end
            n_res++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one request, held until taken, with an optional idle gap first
    task automatic send(rmq_req_t rq, bit gaps);
        while (gaps && $urandom_range(99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        quat_queue.push_back(quat_of(rq));
        n_req++;
    endtask

    function automatic rmq_req_t mk(elem_t a, elem_t b, elem_t c, elem_t d, elem_t e,
                                    elem_t f, elem_t g, elem_t h, elem_t x);
        rmq_req_t rq;
        rq = '{a, b, c, d, e, f, g, h, x};
        return rq;
    endfunction

    function automatic elem_t near(int v);
        return elem_t'(v + $signed($urandom_range(600)) - 300);
    endfunction

    // random matrix: mostly paired off-diagonals, some near a z half turn, rest raw bits
    function automatic rmq_req_t rand_matrix();
        rmq_req_t rq;
        int kind;
        kind = $urandom_range(9);
        rq = rmq_req_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
        if (kind < 6)
        begin
            rq.e00 = elem_t'($urandom_range(32767) - 16384);
            rq.e11 = elem_t'($urandom_range(32767) - 16384);
            rq.e22 = elem_t'($urandom_range(32767) - 16384);
            rq.e01 = elem_t'($urandom_range(32767) - 16384);
            rq.e10 = near(-int'(rq.e01));
            rq.e02 = elem_t'($urandom_range(32767) - 16384);
            rq.e20 = near(kind[0] ? int'(rq.e02) : -int'(rq.e02));
            rq.e12 = elem_t'($urandom_range(32767) - 16384);
            rq.e21 = near(-int'(rq.e12));
        end
        else if (kind == 6)
        begin
            rq.e00 = near(-16384);
            rq.e11 = near(-16384);
            rq.e22 = near(16384);
        end
        return rq;
    endfunction

    // directed table: expected results typed in where obvious
    rmq_req_t dir_req[20];
    rmq_res_t dir_res[20];
    bit       dir_known[20];

    initial
    begin
        int n;
        rmq_res_t w;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        n_err = 0; n_req = 0; n_res = 0; n_invalid = 0; cycles = 0;
        n = 0;
        // identity gives w = 1
        dir_req[n] = mk(P1, 0, 0, 0, P1, 0, 0, 0, P1);
        dir_res[n] = '{16'sh4000, 0, 0, 0, 1'b0}; dir_known[n++] = 1;
        // half turns about each axis
        dir_req[n] = mk(P1, 0, 0, 0, M1, 0, 0, 0, M1);
        dir_res[n] = '{0, 16'sh4000, 0, 0, 1'b0}; dir_known[n++] = 1;
        dir_req[n] = mk(M1, 0, 0, 0, P1, 0, 0, 0, M1);
        dir_res[n] = '{0, 0, 16'sh4000, 0, 1'b0}; dir_known[n++] = 1;
        dir_req[n] = mk(M1, 0, 0, 0, M1, 0, 0, 0, P1);
        dir_res[n] = '{0, 0, 0, 16'sh4000, 1'b0}; dir_known[n++] = 1;
        // all zero: x leads with root argument of one, giving one half
        dir_req[n] = '0;
        dir_res[n] = '{0, 16'sh2000, 0, 0, 1'b0}; dir_known[n++] = 1;
        // all most negative
        dir_req[n] = {9{MINV}}; dir_known[n++] = 0;
        // diagonal ties, lower index wins; then a clear y lead
        dir_req[n] = mk(M1, 100, 200, 300, M1, 400, 500, 600, M1); dir_known[n++] = 0;
        dir_req[n] = mk(0, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, 0); dir_known[n++] = 0;
        dir_req[n] = mk(MINV, 0, 0, 0, MAXV, 0, 0, 0, MINV); dir_known[n++] = 0;
        // extremes of the fields
        dir_req[n] = {9{MAXV}}; dir_known[n++] = 0;
        dir_req[n] = mk(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV);
        dir_known[n++] = 0;
        dir_req[n] = mk(MINV, MAXV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV);
        dir_known[n++] = 0;
        // trace just positive with a root near one, one with saturating components, then a z lead
        dir_req[n] = mk(1, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, 0); dir_known[n++] = 0;
        dir_req[n] = mk(0, 0, 0, 0, 0, 0, 0, 0, 1); dir_known[n++] = 0;
        dir_req[n] = mk(M1, MAXV, 0, MAXV, MINV, 0, 0, 0, 16'sh7000); dir_known[n++] = 0;
        // y leads with small odd off-diagonal terms
        dir_req[n] = mk(16'sh0001, 5, 7, 9, 16'sh2000, 11, 13, 15, -16'sh6000);
        dir_known[n++] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int t = 0; t < n; t++)
        begin
            send(dir_req[t], 1);
            if (dir_known[t])
            begin
                w = quat_of(dir_req[t]);
                if (w !== dir_res[t])
                    report("table", w, dir_res[t]);
            end
        end
        // drain once before the random part
        start <= 1'b0;
        while (quat_queue.size() != 0)
            @(posedge clk);
        // random: gaps, then a gap-free burst, then gaps again
        for (int t = 0; t < N_RANDOM; t++)
            send(rand_matrix(), !(t >= 200 && t < 500));
        start <= 1'b0;
        while (quat_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        $display("sent %0d matrices, checked %0d quaternions (%0d invalid)",
                 n_req, n_res, n_invalid);
        if (n_err == 0 && quat_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* files.f */
hdl/rmq_pkg.sv
hdl/rmq_front.sv
hdl/rmq_queue.sv
hdl/rmq_back.sv
hdl/rotation_matrix_to_quaternion_top.sv
hdl/rmq_checker.sv
dv/tb.sv
